FILE: sv/rgbnv_pkg.sv
package rgbnv_pkg;

    // default size limits of the line buffer and the row counter
    localparam int DEF_MAX_WIDTH  = 2048;
    localparam int DEF_MAX_HEIGHT = 2048;

    localparam int PIX_W  = 8;
    localparam int CFG_W  = 12;
    localparam int LINE_W = 9;

    localparam logic [CFG_W-1:0] RST_IMAGE_WIDTH  = 12'd640;
    localparam logic [CFG_W-1:0] RST_IMAGE_HEIGHT = 12'd480;

    // configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'd1;

    // bt.601 studio-range coefficients (magnitudes, signs in the datapath)
    localparam int Y_COEF_R = 66;
    localparam int Y_COEF_G = 129;
    localparam int Y_COEF_B = 25;
    localparam int U_COEF_R = 38;
    localparam int U_COEF_G = 74;
    localparam int U_COEF_B = 112;
    localparam int V_COEF_R = 112;
    localparam int V_COEF_G = 94;
    localparam int V_COEF_B = 18;
    localparam int ROUND    = 128;
    localparam int Y_OFFSET = 16;
    localparam int CLIP_MAX = 255;
    // rounding plus a bias that keeps the chroma sum positive before the shift
    localparam int CHROMA_BIAS = ROUND + 32768;

    typedef struct packed {
        logic col_odd;
        logic row_odd;
        logic frame_end;
    } pix_flags_t;

endpackage

FILE: sv/rgbnv_ram.sv
module rgbnv_ram #(
    parameter int WIDTH = 18,
    parameter int DEPTH = 1024,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: sv/rgbnv_pos.sv
module rgbnv_pos #(
    parameter int MAX_WIDTH  = rgbnv_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = rgbnv_pkg::DEF_MAX_HEIGHT,
    localparam int AW = (MAX_WIDTH / 2 > 1) ? $clog2(MAX_WIDTH / 2) : 1
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [rgbnv_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [rgbnv_pkg::CFG_W-1:0]         cfg_data,
    input  logic                                advance,
    output rgbnv_pkg::pix_flags_t               flags,
    output logic [AW-1:0]                       slot
);

    localparam int CW  = AW + 1;
    localparam int RW  = (MAX_HEIGHT > 2) ? $clog2(MAX_HEIGHT) : 1;
    localparam int WSW = (CW + 1 > rgbnv_pkg::CFG_W) ? CW + 1 : rgbnv_pkg::CFG_W;
    localparam int HSW = (RW + 1 > rgbnv_pkg::CFG_W) ? RW + 1 : rgbnv_pkg::CFG_W;

    logic [rgbnv_pkg::CFG_W-1:0] width_reg, width_next;
    logic [rgbnv_pkg::CFG_W-1:0] height_reg, height_next;
    logic [CW-1:0] col_cnt_reg, col_cnt_next;
    logic [RW-1:0] row_cnt_reg, row_cnt_next;

    logic [WSW-1:0] w_even, w_eff, w_m1, col_ext;
    logic [HSW-1:0] h_even, h_eff, h_m1, row_ext;
    logic [CW-1:0]  col;
    logic [RW-1:0]  row;
    logic           last_col, last_row;

    always_comb
    begin
        width_next  = width_reg;
        height_next = height_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                rgbnv_pkg::REG_IMAGE_WIDTH:  width_next  = cfg_data;
                rgbnv_pkg::REG_IMAGE_HEIGHT: height_next = cfg_data;
                default: ;
            endcase
        end
    end

    // even size saturated to 2..max
    always_comb
    begin
        w_even = WSW'({width_reg[rgbnv_pkg::CFG_W-1:1], 1'b0});
        priority if (w_even < WSW'(2))
            w_eff = WSW'(2);
        else if (w_even > WSW'(MAX_WIDTH))
            w_eff = WSW'(MAX_WIDTH) & ~WSW'(1);
        else
            w_eff = w_even;
        w_m1    = w_eff - WSW'(1);
        col_ext = WSW'(col_cnt_reg);
        // a counter past the last column after a size change sits on the last one
        col      = (col_ext < w_eff) ? col_cnt_reg : CW'(w_m1);
        last_col = (WSW'(col) == w_m1);
    end

    always_comb
    begin
        h_even = HSW'({height_reg[rgbnv_pkg::CFG_W-1:1], 1'b0});
        priority if (h_even < HSW'(2))
            h_eff = HSW'(2);
        else if (h_even > HSW'(MAX_HEIGHT))
            h_eff = HSW'(MAX_HEIGHT) & ~HSW'(1);
        else
            h_eff = h_even;
        h_m1     = h_eff - HSW'(1);
        row_ext  = HSW'(row_cnt_reg);
        row      = (row_ext < h_eff) ? row_cnt_reg : RW'(h_m1);
        last_row = (HSW'(row) == h_m1);
    end

    always_comb
    begin
        col_cnt_next = col_cnt_reg;
        row_cnt_next = row_cnt_reg;
        if (advance)
        begin
            if (last_col)
            begin
                col_cnt_next = '0;
                row_cnt_next = last_row ? '0 : RW'(row + RW'(1));
            end
            else
            begin
                col_cnt_next = CW'(col + CW'(1));
                row_cnt_next = row;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg   <= rgbnv_pkg::RST_IMAGE_WIDTH;
            height_reg  <= rgbnv_pkg::RST_IMAGE_HEIGHT;
            col_cnt_reg <= '0;
            row_cnt_reg <= '0;
        end
        else
        begin
            width_reg   <= width_next;
            height_reg  <= height_next;
            col_cnt_reg <= col_cnt_next;
            row_cnt_reg <= row_cnt_next;
        end
    end

    assign flags = '{col_odd: col[0], row_odd: row[0], frame_end: last_col & last_row};
    assign slot  = col[CW-1:1];

endmodule

FILE: sv/rgbnv_csc.sv
module rgbnv_csc (
    input  logic [rgbnv_pkg::PIX_W-1:0] red,
    input  logic [rgbnv_pkg::PIX_W-1:0] green,
    input  logic [rgbnv_pkg::PIX_W-1:0] blue,
    output logic [rgbnv_pkg::PIX_W-1:0] luma,
    output logic [rgbnv_pkg::PIX_W-1:0] u,
    output logic [rgbnv_pkg::PIX_W-1:0] v
);

    logic [15:0] y_acc;
    logic [8:0]  y_off;
    logic [16:0] u_acc;
    logic [16:0] v_acc;

    always_comb
    begin
        y_acc = 16'(rgbnv_pkg::Y_COEF_R * red) + 16'(rgbnv_pkg::Y_COEF_G * green)
              + 16'(rgbnv_pkg::Y_COEF_B * blue) + 16'(rgbnv_pkg::ROUND);
        y_off = {1'b0, y_acc[15:8]} + 9'(rgbnv_pkg::Y_OFFSET);
        luma  = (y_off > 9'(rgbnv_pkg::CLIP_MAX)) ? 8'(rgbnv_pkg::CLIP_MAX) : y_off[7:0];

        // biased sums stay in 0..65535, so bits 15:8 give floor((sum+128)/256)+128
        u_acc = 17'(rgbnv_pkg::U_COEF_B * blue) + 17'(rgbnv_pkg::CHROMA_BIAS)
              - 17'(rgbnv_pkg::U_COEF_R * red) - 17'(rgbnv_pkg::U_COEF_G * green);
        v_acc = 17'(rgbnv_pkg::V_COEF_R * red) + 17'(rgbnv_pkg::CHROMA_BIAS)
              - 17'(rgbnv_pkg::V_COEF_G * green) - 17'(rgbnv_pkg::V_COEF_B * blue);
        u = u_acc[15:8];
        v = v_acc[15:8];
    end

endmodule

FILE: sv/rgb_to_nv12_converter_unit.sv
// RGB to NV12 (BT.601 studio range) pixel converter. Pixels enter in raster order
// on s_axis at up to one per clock and each gives one item on m_axis through three
// register stages (stage 1, stage 2 and the output register): luma for
// every pixel, plus the 2x2 average of U and V on the odd-row, odd-column pixel
// (m_axis_tuser high, chroma bytes zero otherwise).
// m_axis_tlast marks the last pixel of the frame, after which the row and column
// counters restart. The even-row column-pair sums sit in one line buffer RAM with
// a separate write and read port, so the rate is one pixel per clock unless
// m_axis stalls; the buffer needs no clearing pass after reset. The user writes
// image size on the cfg port only while no pixel is in flight (the block does
// not enforce it); odd sizes lose the low bit, kept in 2..MAX_WIDTH, 2..MAX_HEIGHT.
module rgb_to_nv12_converter_unit #(
    parameter int MAX_WIDTH  = rgbnv_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = rgbnv_pkg::DEF_MAX_HEIGHT
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [rgbnv_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [rgbnv_pkg::CFG_W-1:0]         cfg_data,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [23:0]                         s_axis_tdata,  // red, green, blue
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [23:0]                         m_axis_tdata,  // luma, chroma_u, chroma_v
    output logic                                m_axis_tlast,  // frame_end
    output logic                                m_axis_tuser   // chroma_valid
);

    localparam int DEPTH = MAX_WIDTH / 2;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int PW    = rgbnv_pkg::PIX_W;
    localparam int LW    = rgbnv_pkg::LINE_W;

    // handshake
    logic accept, s1_go, s1_free, s2_go, s2_free, out_free;

    // position of the pixel being accepted
    rgbnv_pkg::pix_flags_t pos_flags;
    logic [AW-1:0]         pos_slot;

    // stage 1: raw pixel
    logic                  s1_valid_reg, s1_valid_next;
    logic [PW-1:0]         s1_red, s1_green, s1_blue;
    rgbnv_pkg::pix_flags_t s1_flags;
    logic [AW-1:0]         s1_slot;
    logic [PW-1:0]         csc_luma, csc_u, csc_v;

    // stage 2: converted pixel, line buffer data arrives here
    logic                  s2_valid_reg, s2_valid_next;
    logic [PW-1:0]         s2_luma, s2_u, s2_v;
    rgbnv_pkg::pix_flags_t s2_flags;
    logic [AW-1:0]         s2_slot;
    logic [PW-1:0]         pair_u_partial_reg, pair_u_partial_next;
    logic [PW-1:0]         pair_v_partial_reg, pair_v_partial_next;
    logic [LW-1:0]         pair_u_sum, pair_v_sum;
    logic [LW:0]           quad_u_sum, quad_v_sum;
    logic                  s2_chroma_valid;

    // line buffer
    logic                  ram_we, ram_re;
    logic [2*LW-1:0]       ram_rdata;

    // output register
    logic                  out_valid_reg, out_valid_next;
    logic [PW-1:0]         out_luma, out_u, out_v;
    logic                  out_cvalid, out_fend;

    assign out_free      = !out_valid_reg || m_axis_tready;
    assign s2_go         = s2_valid_reg && out_free;
    assign s2_free       = !s2_valid_reg || out_free;
    assign s1_go         = s1_valid_reg && s2_free;
    assign s1_free       = !s1_valid_reg || s2_free;
    assign s_axis_tready = s1_free;
    assign accept        = s_axis_tvalid && s1_free;
    assign cfg_ready     = 1'b1;

    rgbnv_pos #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_pos (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .advance   (accept),
        .flags     (pos_flags),
        .slot      (pos_slot)
    );

    rgbnv_csc u_csc (
        .red   (s1_red),
        .green (s1_green),
        .blue  (s1_blue),
        .luma  (csc_luma),
        .u     (csc_u),
        .v     (csc_v)
    );

    // only the block-completing pixel needs the upper row; the writer of that slot
    // is at least two items ahead, so its write has landed before this read
    assign ram_re = s1_go && s1_flags.col_odd && s1_flags.row_odd;
    assign ram_we = s2_go && s2_flags.col_odd && !s2_flags.row_odd;

    rgbnv_ram #(
        .WIDTH (2 * LW),
        .DEPTH (DEPTH)
    ) u_line_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (s2_slot),
        .wdata ({pair_v_sum, pair_u_sum}),
        .re    (ram_re),
        .raddr (s1_slot),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        pair_u_sum      = LW'(pair_u_partial_reg) + LW'(s2_u);
        pair_v_sum      = LW'(pair_v_partial_reg) + LW'(s2_v);
        quad_u_sum      = (LW + 1)'(pair_u_sum) + (LW + 1)'(ram_rdata[LW-1:0]);
        quad_v_sum      = (LW + 1)'(pair_v_sum) + (LW + 1)'(ram_rdata[2*LW-1:LW]);
        s2_chroma_valid = s2_flags.col_odd && s2_flags.row_odd;
    end

    always_comb
    begin
        s1_valid_next       = accept ? 1'b1 : (s1_go ? 1'b0 : s1_valid_reg);
        s2_valid_next       = s1_go ? 1'b1 : (s2_go ? 1'b0 : s2_valid_reg);
        out_valid_next      = s2_go ? 1'b1 : (m_axis_tready ? 1'b0 : out_valid_reg);
        pair_u_partial_next = pair_u_partial_reg;
        pair_v_partial_next = pair_v_partial_reg;
        if (s2_go && !s2_flags.col_odd)
        begin
            pair_u_partial_next = s2_u;
            pair_v_partial_next = s2_v;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg       <= 1'b0;
            s2_valid_reg       <= 1'b0;
            out_valid_reg      <= 1'b0;
            pair_u_partial_reg <= '0;
            pair_v_partial_reg <= '0;
        end
        else
        begin
            s1_valid_reg       <= s1_valid_next;
            s2_valid_reg       <= s2_valid_next;
            out_valid_reg      <= out_valid_next;
            pair_u_partial_reg <= pair_u_partial_next;
            pair_v_partial_reg <= pair_v_partial_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_red   <= s_axis_tdata[7:0];
            s1_green <= s_axis_tdata[15:8];
            s1_blue  <= s_axis_tdata[23:16];
            s1_flags <= pos_flags;
            s1_slot  <= pos_slot;
        end
        if (s1_go)
        begin
            s2_luma  <= csc_luma;
            s2_u     <= csc_u;
            s2_v     <= csc_v;
            s2_flags <= s1_flags;
            s2_slot  <= s1_slot;
        end
        if (s2_go)
        begin
            out_luma   <= s2_luma;
            out_cvalid <= s2_chroma_valid;
            out_u      <= s2_chroma_valid ? quad_u_sum[LW:2] : '0;
            out_v      <= s2_chroma_valid ? quad_v_sum[LW:2] : '0;
            out_fend   <= s2_flags.frame_end;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_v, out_u, out_luma};
    assign m_axis_tlast  = out_fend;
    assign m_axis_tuser  = out_cvalid;

    // chroma bytes are zero unless flagged
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[23:8] == 16'd0)
        else $error("chroma bytes set without chroma_valid");

    // the last pixel of a frame always closes a 2x2 block
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tlast |-> m_axis_tuser)
        else $error("frame end without chroma");

    // a line buffer read never races a write to the same slot
    assert property (@(posedge clk) disable iff (!rst_n)
        !(ram_we && ram_re && (s2_slot == s1_slot)))
        else $error("line buffer read and write collide");

    // stage 2, when blocked downstream, keeps its item
    assert property (@(posedge clk) disable iff (!rst_n)
        s2_valid_reg && !out_free |=> s2_valid_reg && $stable(s2_luma))
        else $error("stage 2 item lost under stall");

endmodule
